// ===== src/stme_pkg.sv =====
package stme_pkg;

    localparam int AddrW   = 48;
    localparam int MetW    = 32;
    localparam int CntW    = 32;
    localparam int HgtW    = 8;
    localparam int TreeW   = 9;
    localparam int CfgW    = 48;
    localparam int CfgIdxW = 2;

    typedef logic [AddrW-1:0]   addr_t;
    typedef logic [MetW-1:0]    met_t;
    typedef logic [CntW-1:0]    cnt_t;
    typedef logic [HgtW-1:0]    hgt_t;
    typedef logic [TreeW-1:0]   tree_t;
    typedef logic [CfgW-1:0]    cfg_data_t;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_OWN_ADDR    = 2'd0;
    localparam cfg_idx_t REG_OWN_METRIC  = 2'd1;
    localparam cfg_idx_t REG_OWN_COUNTER = 2'd2;
    localparam cfg_idx_t REG_MAX_HEIGHT  = 2'd3;

    localparam addr_t OwnAddrRst    = '0;
    localparam met_t  OwnMetricRst  = 32'd60;
    localparam cnt_t  OwnCounterRst = '0;
    localparam hgt_t  MaxHeightRst  = 8'd10;

    typedef struct packed {
        logic  peer_valid;
        hgt_t  peer_height;
        addr_t peer_self_addr;
        addr_t peer_sync_addr;
        addr_t peer_master_addr;
        met_t  peer_master_metric;
        cnt_t  peer_master_counter;
        logic  last_peer;
    } peer_t;

    typedef struct packed {
        addr_t origin;
        addr_t root;
        met_t  metric;
        cnt_t  counter;
        hgt_t  height;
    } cand_t;

    typedef struct packed {
        addr_t top_master_addr;
        addr_t sync_master_addr;
        met_t  top_metric;
        cnt_t  top_counter;
        tree_t tree_height;
        logic  tree_changed;
    } res_t;

endpackage

// ===== src/stme_if.sv =====
interface stme_peer_if;
    import stme_pkg::*;

    logic  valid;
    logic  ready;
    logic  peer_valid;
    hgt_t  peer_height;
    addr_t peer_self_addr;
    addr_t peer_sync_addr;
    addr_t peer_master_addr;
    met_t  peer_master_metric;
    cnt_t  peer_master_counter;
    logic  last_peer;

    modport source (
        output valid, peer_valid, peer_height, peer_self_addr, peer_sync_addr,
               peer_master_addr, peer_master_metric, peer_master_counter, last_peer,
        input  ready
    );
    modport sink (
        input  valid, peer_valid, peer_height, peer_self_addr, peer_sync_addr,
               peer_master_addr, peer_master_metric, peer_master_counter, last_peer,
        output ready
    );
endinterface

interface stme_result_if;
    import stme_pkg::*;

    logic  valid;
    logic  ready;
    addr_t top_master_addr;
    addr_t sync_master_addr;
    met_t  top_metric;
    cnt_t  top_counter;
    tree_t tree_height;
    logic  tree_changed;

    modport source (
        output valid, top_master_addr, sync_master_addr, top_metric, top_counter,
               tree_height, tree_changed,
        input  ready
    );
    modport sink (
        input  valid, top_master_addr, sync_master_addr, top_metric, top_counter,
               tree_height, tree_changed,
        output ready
    );
endinterface

// ===== src/stme_judge.sv =====
module stme_judge (
    input  stme_pkg::peer_t peer,
    input  stme_pkg::cand_t best,
    input  stme_pkg::addr_t own_addr,
    input  stme_pkg::hgt_t  max_height,
    output logic            take
);
    import stme_pkg::*;

    logic too_high;
    logic loops_back;
    logic pair_lower;
    logic pair_equal;
    logic tie_lost;

    always_comb
    begin
        too_high   = ({1'b0, peer.peer_height} + 9'd1) > {1'b0, max_height};
        loops_back = peer.peer_sync_addr == own_addr;
        pair_lower = {peer.peer_master_counter, peer.peer_master_metric}
                     < {best.counter, best.metric};
        pair_equal = {peer.peer_master_counter, peer.peer_master_metric}
                     == {best.counter, best.metric};
        tie_lost   = (peer.peer_height > best.height)
                     || ((peer.peer_height == best.height)
                         && (peer.peer_self_addr <= best.origin));
        take = peer.peer_valid && !too_high && !loops_back && !pair_lower
               && !(pair_equal && tie_lost);
    end

endmodule

// ===== src/sync_tree_master_election.sv =====
// Sync tree master election.
// Peer records arrive as beats on the peer channel (valid/ready); a round
// is a run of beats ending with last_peer set. Each beat is compared with
// the running best candidate, which starts every round as this node.
// On the last beat of a round one result beat is produced on the result
// channel: top master, sync parent, metric, counter, tree height and a
// changed flag against the previous round. Other beats produce nothing.
// Latency: the result is valid the cycle after the last peer beat is taken.
// Throughput: one peer beat per cycle unless a stalled result holds peer ready low;
// the compare against the registered best is combinational.
// The result sits in an output register; while it waits, non-last and last
// beats still flow as long as the receiver drains it in the same cycle,
// otherwise peer ready drops until the result is taken.
// The user writes config (own_addr, own_metric, own_counter, max_height) via
// cfg_we/cfg_index/cfg_data only while the block is idle; it is not enforced.
// Reset: rst_n, asynchronous active low; registers go to their reset
// values, the best candidate is self and the previous-round addresses are 0.
module sync_tree_master_election (
    input  logic                 clk,
    input  logic                 rst_n,
    stme_peer_if.sink            peer,
    stme_result_if.source        result,
    input  logic                 cfg_we,
    input  stme_pkg::cfg_idx_t   cfg_index,
    input  stme_pkg::cfg_data_t  cfg_data
);
    import stme_pkg::*;

    addr_t own_addr_reg;
    met_t  own_metric_reg;
    cnt_t  own_counter_reg;
    hgt_t  max_height_reg;

    logic  best_is_self_reg;
    logic  best_is_self_next;
    cand_t best_reg;
    addr_t prev_master_reg;
    addr_t prev_sync_reg;
    res_t  res_reg;
    res_t  res_next;
    logic  res_valid_reg;
    logic  res_valid_next;

    peer_t pk;
    cand_t self_cand;
    cand_t best_view;
    cand_t peer_cand;
    logic  take;
    logic  in_acc;
    logic  emit;

    assign pk = '{
        peer_valid:          peer.peer_valid,
        peer_height:         peer.peer_height,
        peer_self_addr:      peer.peer_self_addr,
        peer_sync_addr:      peer.peer_sync_addr,
        peer_master_addr:    peer.peer_master_addr,
        peer_master_metric:  peer.peer_master_metric,
        peer_master_counter: peer.peer_master_counter,
        last_peer:           peer.last_peer
    };

    assign peer.ready = !res_valid_reg || result.ready;
    assign in_acc     = peer.valid && peer.ready;
    assign emit       = in_acc && pk.last_peer;

    assign self_cand = '{
        origin:  own_addr_reg,
        root:    own_addr_reg,
        metric:  own_metric_reg,
        counter: own_counter_reg,
        height:  '0
    };
    assign best_view = best_is_self_reg ? self_cand : best_reg;

    assign peer_cand = '{
        origin:  pk.peer_self_addr,
        root:    pk.peer_master_addr,
        metric:  pk.peer_master_metric,
        counter: pk.peer_master_counter,
        height:  pk.peer_height
    };

    stme_judge u_judge (
        .peer       (pk),
        .best       (best_view),
        .own_addr   (own_addr_reg),
        .max_height (max_height_reg),
        .take       (take)
    );

    always_comb
    begin
        best_is_self_next = best_is_self_reg;
        if (in_acc)
        begin
            if (pk.last_peer)
                best_is_self_next = 1'b1;
            else if (take)
                best_is_self_next = 1'b0;
        end

        res_next = res_reg;
        if (take)
        begin
            res_next.top_master_addr  = peer_cand.root;
            res_next.sync_master_addr = peer_cand.origin;
            res_next.top_metric       = peer_cand.metric;
            res_next.top_counter      = peer_cand.counter;
            res_next.tree_height      = {1'b0, peer_cand.height} + 9'd1;
        end
        else if (best_is_self_reg)
        begin
            res_next.top_master_addr  = own_addr_reg;
            res_next.sync_master_addr = own_addr_reg;
            res_next.top_metric       = own_metric_reg;
            res_next.top_counter      = own_counter_reg;
            res_next.tree_height      = '0;
        end
        else
        begin
            res_next.top_master_addr  = best_reg.root;
            res_next.sync_master_addr = best_reg.origin;
            res_next.top_metric       = best_reg.metric;
            res_next.top_counter      = best_reg.counter;
            res_next.tree_height      = {1'b0, best_reg.height} + 9'd1;
        end
        res_next.tree_changed = (res_next.top_master_addr != prev_master_reg)
                                || (res_next.sync_master_addr != prev_sync_reg);

        res_valid_next = res_valid_reg;
        if (emit)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg     <= OwnAddrRst;
            own_metric_reg   <= OwnMetricRst;
            own_counter_reg  <= OwnCounterRst;
            max_height_reg   <= MaxHeightRst;
            best_is_self_reg <= 1'b1;
            prev_master_reg  <= '0;
            prev_sync_reg    <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OWN_ADDR:    own_addr_reg    <= cfg_data[AddrW-1:0];
                    REG_OWN_METRIC:  own_metric_reg  <= cfg_data[MetW-1:0];
                    REG_OWN_COUNTER: own_counter_reg <= cfg_data[CntW-1:0];
                    REG_MAX_HEIGHT:  max_height_reg  <= cfg_data[HgtW-1:0];
                    default: ;
                endcase
            end
            best_is_self_reg <= best_is_self_next;
            res_valid_reg    <= res_valid_next;
            if (emit)
            begin
                prev_master_reg <= res_next.top_master_addr;
                prev_sync_reg   <= res_next.sync_master_addr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && take)
            best_reg <= peer_cand;
        if (emit)
            res_reg <= res_next;
    end

    assign result.valid            = res_valid_reg;
    assign result.top_master_addr  = res_reg.top_master_addr;
    assign result.sync_master_addr = res_reg.sync_master_addr;
    assign result.top_metric       = res_reg.top_metric;
    assign result.top_counter      = res_reg.top_counter;
    assign result.tree_height      = res_reg.tree_height;
    assign result.tree_changed     = res_reg.tree_changed;

`ifndef SYNTH
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> result.valid)
        else $error("last peer beat did not produce a result");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !peer.ready)
        else $error("peer beat taken while result is stalled");

    a_round_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> best_is_self_reg)
        else $error("best candidate not back to self after round end");

    a_self_height: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.tree_height == '0))
            |-> (result.top_master_addr == result.sync_master_addr))
        else $error("height zero result with distinct master and sync");
`endif

endmodule

// ===== sim/sync_tree_master_election_test.sv =====
module sync_tree_master_election_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stme_pkg::*;

    localparam int CycleLimit = 200000;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    stme_peer_if   peer_ch ();
    stme_result_if res_ch ();

    sync_tree_master_election dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .peer      (peer_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // node registers as last written
    addr_t node_addr;
    met_t  node_metric;
    cnt_t  node_counter;
    hgt_t  node_max_hgt;

    // running best candidate of the current round
    logic  cand_is_self;
    addr_t cand_self_addr;
    addr_t cand_master_addr;
    met_t  cand_metric;
    cnt_t  cand_counter;
    hgt_t  cand_height;

    addr_t prev_top_master;
    addr_t prev_sync_parent;

    peer_t pending_peers[$];
    res_t  expected_elections[$];

    peer_t cur_beat;
    res_t  want;
    res_t  got;
    int    send_gap;
    int    take_gap;
    logic  stall_on;
    int    err_count;
    int    cycle_count;

    always #1 clk = ~clk;

    function automatic void elect_step(peer_t p);
        addr_t b_addr;
        met_t  b_met;
        cnt_t  b_cnt;
        hgt_t  b_hgt;
        logic  take;
        res_t  r;
        b_addr = cand_is_self ? node_addr    : cand_self_addr;
        b_met  = cand_is_self ? node_metric  : cand_metric;
        b_cnt  = cand_is_self ? node_counter : cand_counter;
        b_hgt  = cand_is_self ? '0           : cand_height;
        take   = 1'b1;
        if (!p.peer_valid)
            take = 1'b0;
        else if ({1'b0, p.peer_height} + 9'd1 > {1'b0, node_max_hgt})
            take = 1'b0;
        else if (p.peer_sync_addr == node_addr)
            take = 1'b0;
        else if (p.peer_master_counter < b_cnt ||
                 (p.peer_master_counter == b_cnt && p.peer_master_metric < b_met))
            take = 1'b0;
        else if (p.peer_master_counter == b_cnt && p.peer_master_metric == b_met)
        begin
            if (p.peer_height > b_hgt)
                take = 1'b0;
            else if (p.peer_height == b_hgt && p.peer_self_addr <= b_addr)
                take = 1'b0;
        end
        if (take)
        begin
            cand_is_self     = 1'b0;
            cand_self_addr   = p.peer_self_addr;
            cand_master_addr = p.peer_master_addr;
            cand_metric      = p.peer_master_metric;
            cand_counter     = p.peer_master_counter;
            cand_height      = p.peer_height;
        end
        if (p.last_peer)
        begin
            if (cand_is_self)
            begin
                r.top_master_addr  = node_addr;
                r.sync_master_addr = node_addr;
                r.top_metric       = node_metric;
                r.top_counter      = node_counter;
                r.tree_height      = '0;
            end
            else
            begin
                r.top_master_addr  = cand_master_addr;
                r.sync_master_addr = cand_self_addr;
                r.top_metric       = cand_metric;
                r.top_counter      = cand_counter;
                r.tree_height      = {1'b0, cand_height} + 9'd1;
            end
            r.tree_changed = (r.top_master_addr != prev_top_master) ||
                             (r.sync_master_addr != prev_sync_parent);
            prev_top_master  = r.top_master_addr;
            prev_sync_parent = r.sync_master_addr;
            expected_elections.push_back(r);
            cand_is_self     = 1'b1;
            cand_self_addr   = '0;
            cand_master_addr = '0;
            cand_metric      = '0;
            cand_counter     = '0;
            cand_height      = '0;
        end
    endfunction

    function automatic peer_t make_peer(logic v, hgt_t h, addr_t self_a, addr_t sync_a,
                                        addr_t master_a, met_t met, cnt_t cnt, logic last);
        peer_t p;
        p.peer_valid          = v;
        p.peer_height         = h;
        p.peer_self_addr      = self_a;
        p.peer_sync_addr      = sync_a;
        p.peer_master_addr    = master_a;
        p.peer_master_metric  = met;
        p.peer_master_counter = cnt;
        p.last_peer           = last;
        return p;
    endfunction

    function automatic addr_t pick_addr();
        case ($urandom_range(0, 5))
            0: return node_addr;
            1: return node_addr + 1;
            2: return node_addr - 1;
            3: return AddrW'($urandom_range(0, 3));
            4: return '1;
            default: return AddrW'({$urandom, $urandom});
        endcase
    endfunction

    function automatic cnt_t pick_counter();
        case ($urandom_range(0, 5))
            0, 1: return node_counter;
            2: return node_counter + 1;
            3: return node_counter - 1;
            4: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic met_t pick_metric();
        case ($urandom_range(0, 5))
            0, 1: return node_metric;
            2: return node_metric + 1;
            3: return node_metric - 1;
            4: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_OWN_ADDR:    node_addr    = data[AddrW-1:0];
            REG_OWN_METRIC:  node_metric  = data[MetW-1:0];
            REG_OWN_COUNTER: node_counter = data[CntW-1:0];
            REG_MAX_HEIGHT:  node_max_hgt = data[HgtW-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_node(addr_t a, met_t m, cnt_t c, hgt_t h);
        write_reg(REG_OWN_ADDR, a);
        write_reg(REG_OWN_METRIC, {16'd0, m});
        write_reg(REG_OWN_COUNTER, {16'd0, c});
        write_reg(REG_MAX_HEIGHT, {40'd0, h});
    endtask

    // sender holds off until every election result is back, then settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_peers.size() != 0 || peer_ch.valid || expected_elections.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // peer beat driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (peer_ch.valid && peer_ch.ready)
            begin
                elect_step(cur_beat);
                send_gap = stall_on ? $urandom_range(0, 8) : 0;
            end
            if (!peer_ch.valid || peer_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    peer_ch.valid <= 1'b0;
                end
                else if (pending_peers.size() == 0)
                    peer_ch.valid <= 1'b0;
                else
                begin
                    cur_beat = pending_peers.pop_front();
                    peer_ch.valid               <= 1'b1;
                    peer_ch.peer_valid          <= cur_beat.peer_valid;
                    peer_ch.peer_height         <= cur_beat.peer_height;
                    peer_ch.peer_self_addr      <= cur_beat.peer_self_addr;
                    peer_ch.peer_sync_addr      <= cur_beat.peer_sync_addr;
                    peer_ch.peer_master_addr    <= cur_beat.peer_master_addr;
                    peer_ch.peer_master_metric  <= cur_beat.peer_master_metric;
                    peer_ch.peer_master_counter <= cur_beat.peer_master_counter;
                    peer_ch.last_peer           <= cur_beat.last_peer;
                end
            end
        end
    end

    // result beat monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.top_master_addr  = res_ch.top_master_addr;
                got.sync_master_addr = res_ch.sync_master_addr;
                got.top_metric       = res_ch.top_metric;
                got.top_counter      = res_ch.top_counter;
                got.tree_height      = res_ch.tree_height;
                got.tree_changed     = res_ch.tree_changed;
                if (expected_elections.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got %h", $time, got);
                    err_count++;
                end
                else
                begin
                    want = expected_elections.pop_front();
                    compare_field("top_master_addr", want.top_master_addr,
                                  got.top_master_addr);
                    compare_field("sync_master_addr", want.sync_master_addr,
                                  got.sync_master_addr);
                    compare_field("top_metric", 48'(want.top_metric), 48'(got.top_metric));
                    compare_field("top_counter", 48'(want.top_counter), 48'(got.top_counter));
                    compare_field("tree_height", 48'(want.tree_height), 48'(got.tree_height));
                    compare_field("tree_changed", 48'(want.tree_changed),
                                  48'(got.tree_changed));
                end
                take_gap = stall_on ? $urandom_range(0, 8) : 0;
            end
            if (take_gap > 0)
            begin
                take_gap--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int    ph;
        int    n;
        int    rlen;
        int    k;
        peer_t p;
        cnt_t  rc;
        met_t  rm;
        addr_t a;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_OWN_ADDR;
        cfg_data    = '0;
        stall_on    = 1'b1;
        err_count   = 0;
        cycle_count = 0;
        peer_ch.valid               = 1'b0;
        peer_ch.peer_valid          = 1'b0;
        peer_ch.peer_height         = '0;
        peer_ch.peer_self_addr      = '0;
        peer_ch.peer_sync_addr      = '0;
        peer_ch.peer_master_addr    = '0;
        peer_ch.peer_master_metric  = '0;
        peer_ch.peer_master_counter = '0;
        peer_ch.last_peer           = 1'b0;
        res_ch.ready                = 1'b0;

        node_addr    = OwnAddrRst;
        node_metric  = OwnMetricRst;
        node_counter = OwnCounterRst;
        node_max_hgt = MaxHeightRst;
        cand_is_self     = 1'b1;
        cand_self_addr   = '0;
        cand_master_addr = '0;
        cand_metric      = '0;
        cand_counter     = '0;
        cand_height      = '0;
        prev_top_master  = '0;
        prev_sync_parent = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset values of the node registers
        pending_peers.push_back(make_peer(1, 3, 48'h5, 48'h6, 48'h7, 60, 0, 0));
        pending_peers.push_back(make_peer(0, 0, 0, 0, 0, 0, 0, 1));
        wait_idle();

        a = 48'h0000_1111_2222;
        set_node(a, 100, 5, 10);
        pending_peers.push_back(make_peer(0, 0, 0, 0, 0, 0, 0, 1));
        pending_peers.push_back(make_peer(1, 9, 48'h10, 48'h20, 48'h30, 100, 6, 1));
        pending_peers.push_back(make_peer(1, 10, 48'h10, 48'h20, 48'h30, 100, 6, 1));
        pending_peers.push_back(make_peer(1, 255, 48'h10, 48'h20, 48'h30, 100, 6, 1));
        pending_peers.push_back(make_peer(1, 0, 48'h10, a, 48'h30, 100, 9, 1));
        pending_peers.push_back(make_peer(1, 0, 48'h10, 48'h20, 48'h30, 100, 4, 1));
        pending_peers.push_back(make_peer(1, 0, 48'h10, 48'h20, 48'h30, 99, 5, 1));
        pending_peers.push_back(make_peer(1, 1, 48'h10, 48'h20, 48'h30, 100, 5, 1));
        pending_peers.push_back(make_peer(1, 0, a, 48'h20, 48'h30, 100, 5, 1));
        pending_peers.push_back(make_peer(1, 0, a + 1, 48'h20, 48'h30, 100, 5, 1));
        pending_peers.push_back(make_peer(1, 0, a + 1, 48'h20, 48'h30, 100, 5, 1));
        pending_peers.push_back(make_peer(1, 3, 48'h40, 48'h20, 48'h31, 100, 7, 0));
        pending_peers.push_back(make_peer(1, 4, 48'h41, 48'h20, 48'h32, 100, 8, 0));
        pending_peers.push_back(make_peer(1, 0, 48'h42, 48'h20, 48'h33, 100, 7, 0));
        pending_peers.push_back(make_peer(1, 5, 48'h43, 48'h20, 48'h34, 100, 8, 1));
        pending_peers.push_back(make_peer(1, 2, 48'h50, 48'h20, 48'h35, 200, 8, 0));
        pending_peers.push_back(make_peer(1, 2, 48'h51, 48'h20, 48'h36, 200, 8, 1));
        pending_peers.push_back(make_peer(1, 255, '1, '1, '1, '1, '1, 1));
        pending_peers.push_back(make_peer(1, 8, '1, '1, '1, '1, '1, 1));
        pending_peers.push_back(make_peer(1, 0, 0, 0, 0, 0, 0, 1));
        pending_peers.push_back(make_peer(0, 8, '1, '1, '1, '1, '1, 1));
        wait_idle();

        // zero max height rejects every peer
        write_reg(REG_MAX_HEIGHT, 48'd0);
        pending_peers.push_back(make_peer(1, 0, 48'h60, 48'h20, 48'h37, '1, '1, 1));
        wait_idle();
        write_reg(REG_MAX_HEIGHT, 48'd1);
        pending_peers.push_back(make_peer(1, 0, 48'h61, 48'h20, 48'h38, 100, 9, 0));
        pending_peers.push_back(make_peer(1, 1, 48'h62, 48'h20, 48'h39, 100, 10, 1));
        wait_idle();
        write_reg(REG_MAX_HEIGHT, 48'd255);
        pending_peers.push_back(make_peer(1, 254, 48'h63, 48'h20, 48'h3a, 100, 9, 0));
        pending_peers.push_back(make_peer(1, 255, 48'h64, 48'h20, 48'h3b, 100, 10, 1));
        wait_idle();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: set_node(AddrW'({$urandom, $urandom}), $urandom, $urandom,
                            HgtW'($urandom_range(1, 20)));
                1: set_node('1, '1, '1, 255);
                2: set_node('0, '0, '0, 1);
                default: set_node(AddrW'($urandom_range(0, 3)), $urandom_range(0, 3),
                                  $urandom_range(0, 3), HgtW'($urandom_range(2, 12)));
            endcase
            stall_on = (ph % 3) != 2;
            n = 0;
            while (n < 100)
            begin
                rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                   : $urandom_range(1, 5);
                rc = pick_counter();
                rm = pick_metric();
                for (k = 0; k < rlen; k++)
                begin
                    p.peer_valid  = ($urandom_range(0, 9) != 0);
                    p.peer_height = ($urandom_range(0, 7) == 0)
                                    ? HgtW'($urandom_range(0, 255))
                                    : HgtW'($urandom_range(0, node_max_hgt));
                    p.peer_self_addr   = pick_addr();
                    p.peer_sync_addr   = ($urandom_range(0, 7) == 0)
                                         ? node_addr
                                         : AddrW'({$urandom, $urandom});
                    p.peer_master_addr = pick_addr();
                    p.peer_master_counter = $urandom_range(0, 1) ? rc : pick_counter();
                    p.peer_master_metric  = $urandom_range(0, 1) ? rm : pick_metric();
                    p.last_peer = (k == rlen - 1);
                    pending_peers.push_back(p);
                    n++;
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0 && expected_elections.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/stme_pkg.sv
src/stme_if.sv
src/stme_judge.sv
src/sync_tree_master_election.sv
sim/sync_tree_master_election_test.sv
